@@ rtl/pdf_pkg.sv @@
// Shared types, constants and helpers for the palette DAC with fade.
`default_nettype none
package pdf_pkg;

   localparam int DEFAULT_ENTRIES = 256;

   localparam logic [6:0] DARK_FULL  = 7'd64;
   localparam logic [6:0] FADE_TOTAL = 7'd40;
   localparam logic [7:0] DIV5_MUL   = 8'd205;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_BRIGHT = 2'd1,
      FUNC_FADE   = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic       fade;
      logic [6:0] factor;
      logic [5:0] base_r;
      logic [5:0] base_g;
      logic [5:0] base_b;
   } recalc_cfg_type;

   function automatic logic [7:0] expand6(input logic [5:0] v);
      expand6 = {v, v[5:4]};
   endfunction

endpackage
`default_nettype wire

@@ rtl/pdf_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module pdf_ram
   import pdf_pkg::*;
#(
   parameter int WIDTH = 24,
   parameter int DEPTH = DEFAULT_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/pdf_recalc.sv @@
// Pipelined brightness and fade recompute from palette words to DAC words.
`default_nettype none
module pdf_recalc
   import pdf_pkg::*;
#(
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire recalc_cfg_type    cfg,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic [17:0]       pal_data,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [23:0]       wr_data,
   output logic                   pipe_busy
);

   logic              v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0] a1_ff, a2_ff, a3_ff;
   logic [11:0]       prod_ff [3];
   logic [11:0]       prod_in [3];
   logic [2:0]        neg2_ff, neg3_ff, neg_in;
   logic [5:0]        q_ff [3];
   logic [5:0]        q_in [3];
   logic [5:0]        base [3];
   logic [5:0]        chan [3];
   logic [5:0]        res  [3];

   always_comb begin
      logic [6:0]  diff;
      logic [5:0]  mag;
      logic [15:0] scaled;
      base[2] = cfg.base_r;
      base[1] = cfg.base_g;
      base[0] = cfg.base_b;
      chan[2] = pal_data[17:12];
      chan[1] = pal_data[11:6];
      chan[0] = pal_data[5:0];
      for (int c = 0; c < 3; c++) begin
         diff = {1'b0, chan[c]} - {1'b0, base[c]};
         neg_in[c] = diff[6];
         mag = diff[6] ? 6'(-diff) : diff[5:0];
         prod_in[c] = cfg.fade ? 12'(mag * cfg.factor) : 12'(chan[c] * cfg.factor);
         scaled = 16'(prod_ff[c][11:3] * DIV5_MUL);
         q_in[c] = cfg.fade ? scaled[15:10] : prod_ff[c][11:6];
         if (!cfg.fade) begin
            res[c] = q_ff[c];
         end else if (neg3_ff[c]) begin
            res[c] = base[c] - q_ff[c];
         end else begin
            res[c] = base[c] + q_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff   <= rd_addr;
      a2_ff   <= a1_ff;
      a3_ff   <= a2_ff;
      neg2_ff <= neg_in;
      neg3_ff <= neg2_ff;
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= prod_in[c];
         q_ff[c]    <= q_in[c];
      end
   end

   assign wr_en     = v3_ff;
   assign wr_addr   = a3_ff;
   assign wr_data   = {expand6(res[2]), expand6(res[1]), expand6(res[0])};
   assign pipe_busy = v1_ff | v2_ff | v3_ff;

endmodule
`default_nettype wire

@@ rtl/palette_dac_with_fade.sv @@
// Top level of the palette DAC: palette and DAC stores, sweep control and result port.
//
// Channel   Ports                                   Handshake
// request   req_func/index/red/green/blue/level     start high, busy low
// response  rsp_red_out/green_out/blue_out          rsp_valid, one cycle, no stall
//
// For write and lookup the word appears the cycle after acceptance, and a new word
// is taken every cycle while busy is low.
// Brightness and fade recomputes sweep the palette memory one entry per cycle while
// busy is high: brightness from entry 0, fade from req_index to the last entry.
// After reset both stores are cleared while busy is high.
`default_nettype none
module palette_dac_with_fade
   import pdf_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_index,
   input  wire logic [5:0] req_red,
   input  wire logic [5:0] req_green,
   input  wire logic [5:0] req_blue,
   input  wire logic [6:0] req_level,
   output logic            rsp_valid,
   output logic      [7:0] rsp_red_out,
   output logic      [7:0] rsp_green_out,
   output logic      [7:0] rsp_blue_out
);

   localparam int AW = $clog2(ENTRIES);

   state_type      state_ff, state_in;
   logic [AW-1:0]  addr_ff, addr_in;
   recalc_cfg_type cfg_ff, cfg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           lookup_ff, lookup_in;

   logic           in_range;
   func_type       func;
   logic           pal_we, pal_re, dac_we, dac_re;
   logic [AW-1:0]  pal_waddr, dac_waddr, dac_raddr;
   logic [17:0]    pal_wdata, pal_rdata;
   logic [23:0]    dac_wdata, dac_rdata;
   logic           rc_we, pipe_busy;
   logic [AW-1:0]  rc_waddr;
   logic [23:0]    rc_wdata;
   logic [6:0]     dark, steps;

   assign func     = func_type'(req_func);
   assign in_range = {1'b0, req_index} < 9'(ENTRIES);
   assign dark     = (req_level > DARK_FULL) ? DARK_FULL : req_level;
   assign steps    = (req_level > FADE_TOTAL) ? FADE_TOTAL : req_level;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cfg_in       = cfg_ff;
      rsp_valid_in = 1'b0;
      lookup_in    = 1'b0;
      busy         = 1'b1;
      pal_we       = 1'b0;
      pal_waddr    = addr_ff;
      pal_wdata    = '0;
      pal_re       = 1'b0;
      dac_we       = 1'b0;
      dac_waddr    = addr_ff;
      dac_wdata    = '0;
      dac_re       = 1'b0;
      dac_raddr    = req_index[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            pal_we = 1'b1;
            dac_we = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (func)
                  FUNC_WRITE: begin
                     rsp_valid_in = 1'b1;
                     pal_we       = in_range;
                     dac_we       = in_range;
                     pal_waddr    = req_index[AW-1:0];
                     dac_waddr    = req_index[AW-1:0];
                     pal_wdata    = {req_red, req_green, req_blue};
                     dac_wdata    = {expand6(req_red), expand6(req_green),
                                     expand6(req_blue)};
                  end
                  FUNC_BRIGHT: begin
                     cfg_in   = '{fade: 1'b0, factor: DARK_FULL - dark,
                                  base_r: req_red, base_g: req_green, base_b: req_blue};
                     addr_in  = '0;
                     state_in = ST_SWEEP;
                  end
                  FUNC_FADE: begin
                     cfg_in   = '{fade: 1'b1, factor: steps,
                                  base_r: req_red, base_g: req_green, base_b: req_blue};
                     addr_in  = req_index[AW-1:0];
                     state_in = in_range ? ST_SWEEP : ST_DRAIN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     lookup_in    = in_range;
                     dac_re       = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            pal_re  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rc_we) begin
         dac_we    = 1'b1;
         dac_waddr = rc_waddr;
         dac_wdata = rc_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lookup_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         lookup_ff    <= lookup_in;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   pdf_ram #(.WIDTH(18), .DEPTH(ENTRIES)) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_waddr),
      .wr_data (pal_wdata),
      .rd_en   (pal_re),
      .rd_addr (addr_ff),
      .rd_data (pal_rdata)
   );

   pdf_ram #(.WIDTH(24), .DEPTH(ENTRIES)) u_dac_ram (
      .clock   (clock),
      .wr_en   (dac_we),
      .wr_addr (dac_waddr),
      .wr_data (dac_wdata),
      .rd_en   (dac_re),
      .rd_addr (dac_raddr),
      .rd_data (dac_rdata)
   );

   pdf_recalc #(.ADDR_W(AW)) u_recalc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .rd_en     (pal_re),
      .rd_addr   (addr_ff),
      .pal_data  (pal_rdata),
      .wr_en     (rc_we),
      .wr_addr   (rc_waddr),
      .wr_data   (rc_wdata),
      .pipe_busy (pipe_busy)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = lookup_ff ? dac_rdata[23:16] : 8'd0;
   assign rsp_green_out = lookup_ff ? dac_rdata[15:8]  : 8'd0;
   assign rsp_blue_out  = lookup_ff ? dac_rdata[7:0]   : 8'd0;

endmodule
`default_nettype wire
